[hdl/lkv_pkg.sv]
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and codes for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  // Request command codes
  typedef enum logic [0:0] {
    CMD_SET = 1'b0,
    CMD_GET = 1'b1
  } lkv_cmd_e;

  // Per-cycle control broadcast from the top level to every cell
  typedef struct packed {
    logic step;       // update the chain this cycle
    logic shift_all;  // every cell takes its neighbor (insert at head)
  } lkv_ctrl_t;

endpackage

[hdl/lkv_if.sv]
// ----------------------------------------------------------------------------
// lkv_req_if / lkv_rsp_if
// Valid/ready channels carrying cache requests and results.
// ----------------------------------------------------------------------------
interface lkv_req_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] write_value;

  modport source (output valid, command, key, write_value, input ready);
  modport sink   (input valid, command, key, write_value, output ready);
endinterface

interface lkv_rsp_if #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;

  modport source (output valid, hit, read_value, evicted, input ready);
  modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

[hdl/lkv_cell.sv]
// ----------------------------------------------------------------------------
// lkv_cell
// One slot of the recency-ordered chain: compares its key with the request,
// and on a step takes the entry of its more recent neighbor.
// ----------------------------------------------------------------------------
module lkv_cell #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lkv_pkg::lkv_ctrl_t    ctrl_i,
  input  logic [KEY_BITS-1:0]   req_key_i,
  // entry of the more recent neighbor (head entry for the first cell)
  input  logic                  prev_valid_i,
  input  logic [KEY_BITS-1:0]   prev_key_i,
  input  logic [VALUE_BITS-1:0] prev_value_i,
  // own entry, to the less recent neighbor
  output logic                  valid_o,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] value_o,
  // match seen here or further back in the chain
  input  logic                  below_i,
  output logic                  below_o,
  // hit value gathered along the chain
  input  logic [VALUE_BITS-1:0] acc_i,
  output logic [VALUE_BITS-1:0] acc_o
);
  import lkv_pkg::*;

  logic                  valid_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  match;
  logic                  shift_en;

  // Tag compare and chain terms
  assign match    = valid_q && (key_q == req_key_i);
  assign below_o  = match || below_i;
  assign acc_o    = acc_i | (match ? value_q : '0);
  assign shift_en = ctrl_i.step && (ctrl_i.shift_all || below_o);

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_en) begin
      valid_q <= prev_valid_i;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      key_q   <= prev_key_i;
      value_q <= prev_value_i;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign value_o = value_q;

endmodule

[hdl/lru_key_value_cache.sv]
// Datapath: the request register is loaded when a request is accepted, then
//   parallel compare and chain shift fill the result register once it is
//   free or its result is being taken.
// Throughput: one item per cycle while results are taken; the chain of cells
//   is updated once for each set and each get hit; a get miss leaves it as is.
// Reset: asynchronous, active low; clears all entry valid flags and the
//   handshake state. Keys and values are not cleared.
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value store kept in recency order along a chain of
// cells: the head is most recent, the tail is the replacement victim.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  lkv_req_if.sink   req_i,
  lkv_rsp_if.source rsp_o
);
  import lkv_pkg::*;

  // Request register
  logic                  busy_q;
  logic                  cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] wval_q;

  // Result register
  logic                  out_valid_q;
  logic                  out_hit_q;
  logic [VALUE_BITS-1:0] out_value_q;
  logic                  out_evicted_q;

  logic      proc;
  logic      accept;
  logic      is_get;
  logic      hit;
  lkv_ctrl_t ctrl;

  // Chain wiring: index 0 is the head entry fed into the first cell
  logic                  ch_valid [ENTRIES+1];
  logic [KEY_BITS-1:0]   ch_key   [ENTRIES+1];
  logic [VALUE_BITS-1:0] ch_value [ENTRIES+1];
  logic                  below    [ENTRIES+1];
  logic [VALUE_BITS-1:0] acc      [ENTRIES+1];

  // Handshake
  assign proc        = busy_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !busy_q || proc;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (proc) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= req_i.command;
      key_q  <= req_i.key;
      wval_q <= req_i.write_value;
    end
  end

  // Lookup result and chain control
  assign is_get         = (cmd_q == CMD_GET);
  assign hit            = below[0];
  assign ctrl.step      = proc && (hit || !is_get);
  assign ctrl.shift_all = !hit;

  // Head entry: the touched or newly inserted pair
  assign ch_valid[0]      = 1'b1;
  assign ch_key[0]        = key_q;
  assign ch_value[0]      = is_get ? acc[ENTRIES] : wval_q;
  assign acc[0]           = '0;
  assign below[ENTRIES]   = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkv_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .req_key_i   (key_q),
      .prev_valid_i(ch_valid[i]),
      .prev_key_i  (ch_key[i]),
      .prev_value_i(ch_value[i]),
      .valid_o     (ch_valid[i+1]),
      .key_o       (ch_key[i+1]),
      .value_o     (ch_value[i+1]),
      .below_i     (below[i+1]),
      .below_o     (below[i]),
      .acc_i       (acc[i]),
      .acc_o       (acc[i+1])
    );
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_hit_q     <= hit;
      out_value_q   <= (is_get && hit) ? acc[ENTRIES] : '0;
      out_evicted_q <= !is_get && !hit && ch_valid[ENTRIES];
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.read_value = out_value_q;
  assign rsp_o.evicted    = out_evicted_q;

endmodule

[hdl/lkv_checker.sv]
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks of the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkv_checker #(
  parameter int VALUE_BITS = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  out_hit_i,
  input logic [VALUE_BITS-1:0] out_value_i,
  input logic                  out_evicted_i
);

  // A stalled result holds its item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_hit_i) && $stable(out_value_i) && $stable(out_evicted_i))
    else $error("result changed while stalled");

  // An eviction only happens on a miss
  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_evicted_i |-> !out_hit_i)
    else $error("eviction reported together with hit");

  // A miss returns a zero value
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_hit_i |-> out_value_i == '0)
    else $error("nonzero read value on a miss");

  // A result appearing from an empty output comes from an accepted item that passed the request register
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a matching request");

endmodule

bind lru_key_value_cache lkv_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_lkv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_hit_i    (rsp_o.hit),
  .out_value_i  (rsp_o.read_value),
  .out_evicted_i(rsp_o.evicted)
);

[tb/sv/tb_lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking bench for the LRU key-value cache. A short table of directed
// requests covers empty lookups, the all-zero and all-one keys and values,
// overwrites, filling the store and the first eviction. Random set/get
// traffic over a drifting pool of keys follows. A recency-ranked shadow store
// predicts every result, and each result is compared field by field.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import lkv_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int RANK_BITS   = $clog2(ENTRIES);
  localparam int RAND_ITEMS  = 850;
  localparam int POOL_SIZE   = 24;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic   hit;
    value_t read_value;
    logic   evicted;
  } cache_result_t;

  // One directed request; fixed rows carry their result, others use the shadow
  typedef struct {
    lkv_cmd_e cmd;
    key_t     key;
    value_t   value;
    bit       fixed;
    logic     hit;
    value_t   read_value;
    logic     evicted;
  } directed_row_t;

  localparam int NUM_DIRECTED = 25;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // empty store, extremes of key and value, overwrite
    '{CMD_GET, 32'h0000_0000, 32'hDEAD_BEEF, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
    '{CMD_SET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
    '{CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{CMD_SET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
    '{CMD_SET, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
    '{CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
    '{CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678, 1'b0},
    '{CMD_GET, 32'hA5A5_A5A5, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
    // fill the remaining free entries
    '{CMD_SET, 32'h0000_0101, 32'h5555_0001, 1'b0, 1'b0, '0, 1'b0},
    '{CMD_SET, 32'h0000_0102, 32'h5555_0002, 1'b0, 1'b0, '0, 1'b0},
    '{CMD_SET, 32'h0000_0103, 32'h5555_0003, 1'b0, 1'b0, '0, 1'b0},
    '{CMD_SET, 32'h0000_0104, 32'h5555_0004, 1'b0, 1'b0, '0, 1'b0},
    '{CMD_SET, 32'h0000_0105, 32'h5555_0005, 1'b0, 1'b0, '0, 1'b0},
    '{CMD_SET, 32'h0000_0106, 32'h5555_0006, 1'b0, 1'b0, '0, 1'b0},
    '{CMD_SET, 32'h0000_0107, 32'h5555_0007, 1'b0, 1'b0, '0, 1'b0},
    '{CMD_SET, 32'h0000_0108, 32'h5555_0008, 1'b0, 1'b0, '0, 1'b0},
    '{CMD_SET, 32'h0000_0109, 32'h5555_0009, 1'b0, 1'b0, '0, 1'b0},
    '{CMD_SET, 32'h0000_010A, 32'h5555_000A, 1'b0, 1'b0, '0, 1'b0},
    '{CMD_SET, 32'h0000_010B, 32'h5555_000B, 1'b0, 1'b0, '0, 1'b0},
    '{CMD_SET, 32'h0000_010C, 32'h5555_000C, 1'b0, 1'b0, '0, 1'b0},
    '{CMD_SET, 32'h0000_010D, 32'h5555_000D, 1'b0, 1'b0, '0, 1'b0},
    '{CMD_SET, 32'h0000_010E, 32'h5555_000E, 1'b0, 1'b0, '0, 1'b0},
    // store is full: the all-one key is least recent and gets replaced
    '{CMD_SET, 32'h5A5A_5A5A, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0000_0000, 1'b1},
    '{CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
    '{CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  lkv_req_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) req_if ();
  lkv_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_if ();

  lru_key_value_cache #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow store: rank 0 is most recent, ENTRIES-1 is the replacement victim
  logic                 shadow_valid [ENTRIES];
  key_t                 shadow_key   [ENTRIES];
  value_t               shadow_value [ENTRIES];
  logic [RANK_BITS-1:0] shadow_rank  [ENTRIES];

  cache_result_t pending_results [$];

  int error_count;
  int requests_sent;
  int results_seen;
  int hits_seen;
  int evictions_seen;
  int burst_left;

  key_t key_pool [POOL_SIZE];
  int   working_set;

  // Clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Watchdog
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Move one entry to the front; everything ahead of it slides back by one
  function automatic void promote_entry(int idx);
    logic [RANK_BITS-1:0] old_rank;
    old_rank = shadow_rank[idx];
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_rank[i] < old_rank) shadow_rank[i] = shadow_rank[i] + 1'b1;
    end
    shadow_rank[idx] = '0;
  endfunction

  function automatic cache_result_t predict_access(lkv_cmd_e cmd, key_t key, value_t value);
    cache_result_t res;
    int            found;
    int            victim;
    res    = '0;
    found  = -1;
    victim = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_key[i] == key) found = i;
    end
    if (cmd == CMD_GET) begin
      if (found >= 0) begin
        res.hit        = 1'b1;
        res.read_value = shadow_value[found];
        promote_entry(found);
      end
    end else if (found >= 0) begin
      res.hit             = 1'b1;
      shadow_value[found] = value;
      promote_entry(found);
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (shadow_rank[i] == RANK_BITS'(ENTRIES - 1)) victim = i;
      end
      res.evicted          = shadow_valid[victim];
      shadow_valid[victim] = 1'b1;
      shadow_key[victim]   = key;
      shadow_value[victim] = value;
      promote_entry(victim);
    end
    return res;
  endfunction

  // Present one request, honoring the burst/gap pattern; returns once accepted
  task automatic issue_request(lkv_cmd_e cmd, key_t key, value_t value,
                               bit fixed, cache_result_t fixed_res);
    int            gap;
    cache_result_t predicted;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        req_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_if.valid       = 1'b1;
    req_if.command     = cmd;
    req_if.key         = key;
    req_if.write_value = value;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = predict_access(cmd, key, value);
    pending_results.push_back(fixed ? fixed_res : predicted);
    requests_sent++;
  endtask

  // Hold the request side idle until every outstanding result is back
  task automatic wait_until_drained();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    burst_left = 0;
  endtask

  // Keys mostly come from a pool; the working set decides how often we evict
  function automatic key_t pick_key();
    if ($urandom_range(0, 99) < 88) return key_pool[$urandom_range(0, working_set - 1)];
    return key_t'($urandom());
  endfunction

  // Result side stalls in phases of its own
  int unsigned ready_mode;
  int unsigned ready_cycle;

  always @(negedge clk_i) begin
    if (ready_cycle % 50 == 0) ready_mode <= $urandom_range(0, 3);
    ready_cycle <= ready_cycle + 1;
    case (ready_mode)
      0: rsp_if.ready <= 1'b1;
      1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
      2: rsp_if.ready <= (ready_cycle % 4 == 0);
      default: rsp_if.ready <= ($urandom_range(0, 99) < 85);
    endcase
  end

  // Result checker
  always @(posedge clk_i) begin
    cache_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (rsp_if.hit) hits_seen++;
      if (rsp_if.evicted) evictions_seen++;
      if (pending_results.size() == 0) begin
        $error("result arrived with nothing outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.hit !== want.hit) begin
          $error("hit mismatch: expected %0b, got %0b", want.hit, rsp_if.hit);
          error_count++;
        end
        if (rsp_if.read_value !== want.read_value) begin
          $error("read_value mismatch: expected %08h, got %08h",
                 want.read_value, rsp_if.read_value);
          error_count++;
        end
        if (rsp_if.evicted !== want.evicted) begin
          $error("evicted mismatch: expected %0b, got %0b", want.evicted, rsp_if.evicted);
          error_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    cache_result_t row_res;
    lkv_cmd_e      cmd;

    error_count    = 0;
    requests_sent  = 0;
    results_seen   = 0;
    hits_seen      = 0;
    evictions_seen = 0;
    burst_left     = 0;
    ready_mode     = 0;
    ready_cycle    = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
      shadow_rank[i]  = RANK_BITS'(i);
    end

    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.command     = CMD_SET;
    req_if.key         = '0;
    req_if.write_value = '0;
    rsp_if.ready       = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    foreach (directed_rows[r]) begin
      row_res.hit        = directed_rows[r].hit;
      row_res.read_value = directed_rows[r].read_value;
      row_res.evicted    = directed_rows[r].evicted;
      issue_request(directed_rows[r].cmd, directed_rows[r].key, directed_rows[r].value,
                    directed_rows[r].fixed, row_res);
    end
    wait_until_drained();

    // Random traffic
    foreach (key_pool[p]) key_pool[p] = key_t'($urandom());
    working_set = POOL_SIZE;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) begin
        working_set = $urandom_range(8, POOL_SIZE);
        repeat (4) key_pool[$urandom_range(0, POOL_SIZE - 1)] = key_t'($urandom());
      end
      if (n % 200 == 199) wait_until_drained();
      cmd = lkv_cmd_e'($urandom_range(0, 1));
      issue_request(cmd, pick_key(), value_t'($urandom()), 1'b0, '0);
    end

    // Drain, then give a stray result time to show up
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d set/get requests (directed and random) under random stalls on both sides.",
             requests_sent);
    $display("Checked %0d results: %0d hits, %0d evictions.",
             results_seen, hits_seen, evictions_seen);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/lkv_pkg.sv
hdl/lkv_if.sv
hdl/lkv_cell.sv
hdl/lru_key_value_cache.sv
hdl/lkv_checker.sv
tb/sv/tb_lru_key_value_cache.sv
